// ----- sv/ray_aabb_slab_test_defines.svh -----
`ifndef RAY_AABB_SLAB_TEST_DEFINES_SVH
`define RAY_AABB_SLAB_TEST_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define RAB_ASSERT_NOW(label, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("slab test check failed");

// next-cycle implication
`define RAB_ASSERT_NEXT(label, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("slab test check failed");

`endif

// ----- sv/rab_pkg.sv -----
`timescale 1ns / 1ps
package rab_pkg;

    localparam int FRAC_BITS   = 16;
    localparam int COORD_WIDTH = 32;
    localparam int EPS_WIDTH   = 16;
    localparam int DIST_WIDTH  = 31;
    localparam logic [EPS_WIDTH-1:0] EPS_RESET = EPS_WIDTH'(7);

    // divider: operand setup, one stage per quotient bit, sign/clamp
    localparam int DIV_DEPTH  = COORD_WIDTH + 2;
    // lane input register + divider + ordering + merge reduction
    localparam int PIPE_DEPTH = DIV_DEPTH + 3;

    typedef logic signed [COORD_WIDTH-1:0] coord_t;

    localparam coord_t COORD_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};

    typedef struct packed {
        logic   miss;
        coord_t t_lo;
        coord_t t_hi;
    } lane_res_t;

endpackage

// ----- sv/rab_ray_if.sv -----
`timescale 1ns / 1ps
interface rab_ray_if import rab_pkg::*; ();
    logic   valid;
    logic   ready;
    coord_t origin_x;
    coord_t origin_y;
    coord_t origin_z;
    coord_t dir_x;
    coord_t dir_y;
    coord_t dir_z;
    coord_t min_x;
    coord_t min_y;
    coord_t min_z;
    coord_t max_x;
    coord_t max_y;
    coord_t max_z;

    modport source (output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                    min_x, min_y, min_z, max_x, max_y, max_z, input ready);
    modport sink (input valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                  min_x, min_y, min_z, max_x, max_y, max_z, output ready);
endinterface

// ----- sv/rab_hit_if.sv -----
`timescale 1ns / 1ps
interface rab_hit_if import rab_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic                  hit;
    logic [DIST_WIDTH-1:0] hit_distance;

    modport source (output valid, hit, hit_distance, input ready);
    modport sink (input valid, hit, hit_distance, output ready);
endinterface

// ----- sv/rab_cfg_if.sv -----
`timescale 1ns / 1ps
interface rab_cfg_if import rab_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [EPS_WIDTH-1:0] data;

    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

// ----- sv/rab_div.sv -----
`timescale 1ns / 1ps
// Pipelined restoring divider: q = sat((n << FRAC_BITS) / d), one quotient bit per stage.
module rab_div import rab_pkg::*; (
    input  logic                   clk,
    input  logic                   en,
    input  logic [COORD_WIDTH:0]   n_mag,
    input  logic [COORD_WIDTH-1:0] d_mag,
    input  logic                   neg,
    output coord_t                 q
);

    localparam int CW = COORD_WIDTH;
    localparam int SW = COORD_WIDTH - FRAC_BITS;

    logic [CW-1:0] rem_reg [CW+1];
    logic [CW-1:0] quo_reg [CW+1];
    logic [CW-1:0] den_reg [CW+1];
    logic [CW:0]   num_reg [CW+1];
    logic          neg_reg [CW+1];
    logic          ovf_reg [CW+1];
    coord_t        q_reg;

    logic          ovf_next;
    logic [CW-1:0] rem_next;

    // quotient >= 2^CW exactly when n >= d << (CW - FRAC_BITS)
    assign ovf_next = {{(SW){1'b0}}, n_mag} >= {1'b0, d_mag, {(SW){1'b0}}};
    assign rem_next = CW'(n_mag >> SW);

    always_ff @(posedge clk) begin
        if (en)
        begin
            rem_reg[0] <= rem_next;
            quo_reg[0] <= '0;
            den_reg[0] <= d_mag;
            num_reg[0] <= n_mag;
            neg_reg[0] <= neg;
            ovf_reg[0] <= ovf_next;
        end
    end

    for (genvar j = 0; j < CW; j++) begin : g_stage
        localparam int K = CW - 1 - j;
        logic          nbit;
        logic [CW:0]   trial;
        logic [CW:0]   diff;
        logic          ge;

        if (K >= FRAC_BITS) begin : g_nbit
            assign nbit = num_reg[j][K-FRAC_BITS];
        end else begin : g_zero
            assign nbit = 1'b0;
        end

        assign trial = {rem_reg[j], nbit};
        assign ge    = trial >= {1'b0, den_reg[j]};
        assign diff  = trial - {1'b0, den_reg[j]};

        always_ff @(posedge clk) begin
            if (en)
            begin
                rem_reg[j+1] <= ge ? diff[CW-1:0] : trial[CW-1:0];
                quo_reg[j+1] <= {quo_reg[j][CW-2:0], ge};
                den_reg[j+1] <= den_reg[j];
                num_reg[j+1] <= num_reg[j];
                neg_reg[j+1] <= neg_reg[j];
                ovf_reg[j+1] <= ovf_reg[j];
            end
        end
    end

    logic [CW-1:0] lim;
    logic [CW-1:0] sat;

    assign lim = neg_reg[CW] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
    assign sat = (ovf_reg[CW] || quo_reg[CW] > lim) ? lim : quo_reg[CW];

    always_ff @(posedge clk) begin
        if (en)
        begin
            q_reg <= neg_reg[CW] ? coord_t'(-sat) : coord_t'(sat);
        end
    end

    assign q = q_reg;

endmodule

// ----- sv/rab_lane.sv -----
`timescale 1ns / 1ps
// One axis of the slab test: parallel check and the two slab distances.
module rab_lane import rab_pkg::*; (
    input  logic                 clk,
    input  logic                 en,
    input  logic [EPS_WIDTH-1:0] eps,
    input  coord_t               origin,
    input  coord_t               dir,
    input  coord_t               bmin,
    input  coord_t               bmax,
    output lane_res_t            res
);

    localparam int CW = COORD_WIDTH;

    logic signed [CW:0] diff_lo;
    logic signed [CW:0] diff_hi;
    logic [CW-1:0]      dm;

    assign diff_lo = {bmin[CW-1], bmin} - {origin[CW-1], origin};
    assign diff_hi = {bmax[CW-1], bmax} - {origin[CW-1], origin};
    assign dm      = dir[CW-1] ? CW'(-dir) : CW'(dir);

    logic [CW:0]   n_lo_reg;
    logic [CW:0]   n_hi_reg;
    logic          neg_lo_reg;
    logic          neg_hi_reg;
    logic [CW-1:0] dm_reg;
    logic          par_reg  [DIV_DEPTH+1];
    logic          pmiss_reg[DIV_DEPTH+1];

    always_ff @(posedge clk) begin
        if (en)
        begin
            n_lo_reg     <= diff_lo[CW] ? (CW+1)'(-diff_lo) : (CW+1)'(diff_lo);
            n_hi_reg     <= diff_hi[CW] ? (CW+1)'(-diff_hi) : (CW+1)'(diff_hi);
            neg_lo_reg   <= diff_lo[CW] ^ dir[CW-1];
            neg_hi_reg   <= diff_hi[CW] ^ dir[CW-1];
            dm_reg       <= dm;
            par_reg[0]   <= (dm == '0) || (dm < CW'(eps));
            pmiss_reg[0] <= (origin < bmin) || (origin > bmax);
            for (int i = 0; i < DIV_DEPTH; i++) begin
                par_reg[i+1]   <= par_reg[i];
                pmiss_reg[i+1] <= pmiss_reg[i];
            end
        end
    end

    coord_t t1;
    coord_t t2;

    rab_div u_div_lo (
        .clk   (clk),
        .en    (en),
        .n_mag (n_lo_reg),
        .d_mag (dm_reg),
        .neg   (neg_lo_reg),
        .q     (t1)
    );

    rab_div u_div_hi (
        .clk   (clk),
        .en    (en),
        .n_mag (n_hi_reg),
        .d_mag (dm_reg),
        .neg   (neg_hi_reg),
        .q     (t2)
    );

    lane_res_t res_reg;
    lane_res_t res_next;

    always_comb begin
        res_next.miss = par_reg[DIV_DEPTH] && pmiss_reg[DIV_DEPTH];
        if (par_reg[DIV_DEPTH])
        begin
            // parallel axis leaves the interval alone
            res_next.t_lo = '0;
            res_next.t_hi = COORD_MAX;
        end
        else if (t1 > t2)
        begin
            res_next.t_lo = t2;
            res_next.t_hi = t1;
        end
        else
        begin
            res_next.t_lo = t1;
            res_next.t_hi = t2;
        end
    end

    always_ff @(posedge clk) begin
        if (en)
        begin
            res_reg <= res_next;
        end
    end

    assign res = res_reg;

endmodule

// ----- sv/rab_merge.sv -----
`timescale 1ns / 1ps
// Intersects the three lane intervals and holds the result register.
module rab_merge import rab_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic                  valid_in,
    input  lane_res_t             lane [3],
    output logic                  valid,
    output logic                  hit,
    output logic [DIST_WIDTH-1:0] distance
);

    coord_t tmin;
    coord_t tmax;
    logic   miss;

    always_comb begin
        tmin = '0;
        tmax = COORD_MAX;
        miss = 1'b0;
        for (int a = 0; a < 3; a++) begin
            if (lane[a].t_lo > tmin) tmin = lane[a].t_lo;
            if (lane[a].t_hi < tmax) tmax = lane[a].t_hi;
            miss = miss | lane[a].miss;
        end
    end

    logic   hit_reg;
    coord_t tmin_reg;

    always_ff @(posedge clk) begin
        if (en)
        begin
            hit_reg  <= !miss && (tmin <= tmax);
            tmin_reg <= tmin;
        end
    end

    logic [63:0]           tmin_wide;
    logic [DIST_WIDTH-1:0] dist_next;

    assign tmin_wide = 64'($unsigned(tmin_reg));
    assign dist_next = !hit_reg ? '0 :
                       (tmin_wide > 64'({DIST_WIDTH{1'b1}})) ? {DIST_WIDTH{1'b1}} :
                       tmin_wide[DIST_WIDTH-1:0];

    logic                  out_valid_reg;
    logic                  out_hit_reg;
    logic [DIST_WIDTH-1:0] out_dist_reg;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk) begin
        if (en)
        begin
            out_hit_reg  <= hit_reg;
            out_dist_reg <= dist_next;
        end
    end

    assign valid    = out_valid_reg;
    assign hit      = out_hit_reg;
    assign distance = out_dist_reg;

endmodule

// ----- sv/ray_aabb_slab_test.sv -----
// Throughput: one ray-box pair per cycle while the output is not stalled; six dividers, one quotient bit per stage.
// The whole pipeline stalls only while the output register holds an untaken result.
// Reset: rst_n async active low clears valid bits; parallel_epsilon resets to 7.
`timescale 1ns / 1ps
`include "ray_aabb_slab_test_defines.svh"
module ray_aabb_slab_test import rab_pkg::*; (
    input  logic  clk,
    input  logic  rst_n,
    rab_ray_if.sink   ray,
    rab_hit_if.source result,
    rab_cfg_if.sink   cfg
);

    logic [EPS_WIDTH-1:0] eps_reg;
    logic                 en;
    logic                 out_valid;
    logic [PIPE_DEPTH-1:0] v_reg;
    lane_res_t            lane [3];

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            eps_reg <= EPS_RESET;
        end
        else if (cfg.valid)
        begin
            eps_reg <= cfg.data;
        end
    end

    assign en        = !out_valid || result.ready;
    assign ray.ready = en;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[PIPE_DEPTH-2:0], ray.valid};
        end
    end

    rab_lane u_lane_x (
        .clk    (clk),
        .en     (en),
        .eps    (eps_reg),
        .origin (ray.origin_x),
        .dir    (ray.dir_x),
        .bmin   (ray.min_x),
        .bmax   (ray.max_x),
        .res    (lane[0])
    );

    rab_lane u_lane_y (
        .clk    (clk),
        .en     (en),
        .eps    (eps_reg),
        .origin (ray.origin_y),
        .dir    (ray.dir_y),
        .bmin   (ray.min_y),
        .bmax   (ray.max_y),
        .res    (lane[1])
    );

    rab_lane u_lane_z (
        .clk    (clk),
        .en     (en),
        .eps    (eps_reg),
        .origin (ray.origin_z),
        .dir    (ray.dir_z),
        .bmin   (ray.min_z),
        .bmax   (ray.max_z),
        .res    (lane[2])
    );

    rab_merge u_merge (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .valid_in (v_reg[PIPE_DEPTH-1]),
        .lane     (lane),
        .valid    (out_valid),
        .hit      (result.hit),
        .distance (result.hit_distance)
    );

    assign result.valid = out_valid;

    `RAB_ASSERT_NOW(a_miss_zero, result.valid && !result.hit, result.hit_distance == '0)
    `RAB_ASSERT_NOW(a_stall_blocks, result.valid && !result.ready, !ray.ready)
    `RAB_ASSERT_NEXT(a_cfg_write, cfg.valid && cfg.ready, eps_reg == $past(cfg.data))

endmodule

// ----- verif/rab_tb_if.sv -----
`timescale 1ns / 1ps
// The block's interfaces come with the RTL; this file holds the testbench's
// payload types for one ray-box pair and its result so the top file stays focused.
package rab_tb_pkg;
    import rab_pkg::*;

    typedef struct {
        coord_t org [3];
        coord_t dir [3];
        coord_t lo  [3];
        coord_t hi  [3];
    } ray_box_t;

    typedef struct {
        logic                  hit;
        logic [DIST_WIDTH-1:0] distance;
    } hit_res_t;
endpackage

// ----- verif/tb_ray_aabb_slab_test.sv -----
`timescale 1ns / 1ps
module tb_ray_aabb_slab_test;
    import rab_pkg::*;
    import rab_tb_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;

    logic clk;
    logic rst_n;

    rab_ray_if ray_ch ();
    rab_hit_if hit_ch ();
    rab_cfg_if cfg_ch ();

    ray_aabb_slab_test dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .ray    (ray_ch.sink),
        .result (hit_ch.source),
        .cfg    (cfg_ch.sink)
    );

    logic [EPS_WIDTH-1:0] eps_model;
    hit_res_t             expected_hits[$];
    int                   mismatches;
    int                   results_seen;
    int                   hits_seen;
    int                   idle_cycles;
    int                   items_sent;
    bit                   sink_stall_enable;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // (num << FRAC_BITS) / den, truncated toward zero, saturated
    function automatic longint slab_quotient(longint num, longint den);
        bit         neg;
        logic [127:0] n;
        logic [127:0] d;
        logic [127:0] q;
        logic [127:0] lim;
        neg = (num < 0) != (den < 0);
        n = (num < 0) ? -num : num;
        d = (den < 0) ? -den : den;
        lim = neg ? (128'd1 << (COORD_WIDTH - 1)) : ((128'd1 << (COORD_WIDTH - 1)) - 1);
        q = (n << FRAC_BITS) / d;
        if (q > lim)
            q = lim;
        return neg ? -longint'(q) : longint'(q);
    endfunction

    function automatic hit_res_t predict_hit(ray_box_t rb);
        hit_res_t r;
        longint   tmin;
        longint   tmax;
        longint   t1;
        longint   t2;
        longint   o;
        longint   dv;
        longint   lo;
        longint   hi;
        longint   dmag;
        bit       ok;
        tmin = 0;
        tmax = longint'(COORD_MAX);
        ok = 1'b1;
        for (int a = 0; a < 3 && ok; a++)
        begin
            o = rb.org[a];
            dv = rb.dir[a];
            lo = rb.lo[a];
            hi = rb.hi[a];
            dmag = (dv < 0) ? -dv : dv;
            if (dmag == 0 || dmag < longint'(eps_model))
            begin
                if (o < lo || o > hi)
                    ok = 1'b0;
            end
            else
            begin
                t1 = slab_quotient(lo - o, dv);
                t2 = slab_quotient(hi - o, dv);
                if (t1 > t2)
                begin
                    o = t1;
                    t1 = t2;
                    t2 = o;
                end
                if (t1 > tmin)
                    tmin = t1;
                if (t2 < tmax)
                    tmax = t2;
                if (tmin > tmax)
                    ok = 1'b0;
            end
        end
        r.hit = ok;
        r.distance = '0;
        if (ok)
            r.distance = (tmin > 64'h7FFF_FFFF) ? 31'h7FFF_FFFF : tmin[DIST_WIDTH-1:0];
        return r;
    endfunction

    // valid stays high after a transfer so back-to-back items need no gap
    task automatic send_ray(ray_box_t rb);
        int gap;
        gap = $urandom_range(0, 5);
        if ($urandom_range(0, 3) == 0)
            gap = 0;
        if (gap > 0)
        begin
            ray_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        ray_ch.valid    <= 1'b1;
        ray_ch.origin_x <= rb.org[0];
        ray_ch.origin_y <= rb.org[1];
        ray_ch.origin_z <= rb.org[2];
        ray_ch.dir_x    <= rb.dir[0];
        ray_ch.dir_y    <= rb.dir[1];
        ray_ch.dir_z    <= rb.dir[2];
        ray_ch.min_x    <= rb.lo[0];
        ray_ch.min_y    <= rb.lo[1];
        ray_ch.min_z    <= rb.lo[2];
        ray_ch.max_x    <= rb.hi[0];
        ray_ch.max_y    <= rb.hi[1];
        ray_ch.max_z    <= rb.hi[2];
        do
            @(posedge clk);
        while (!ray_ch.ready);
        expected_hits.push_back(predict_hit(rb));
        items_sent++;
    endtask

    task automatic ray_idle();
        ray_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic write_epsilon(logic [EPS_WIDTH-1:0] value);
        ray_idle();
        wait (expected_hits.size() == 0);
        repeat (PIPE_DEPTH + 4) @(posedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= value;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        eps_model = value;
    endtask

    function automatic coord_t rand_coord();
        case ($urandom_range(0, 5))
            0: return coord_t'($urandom);
            1: return coord_t'($urandom_range(0, 200000)) - coord_t'(100000);
            2: return coord_t'($urandom_range(0, 40) - 20) <<< FRAC_BITS;
            3: return $urandom_range(0, 1) ? COORD_MAX : ~COORD_MAX;
            4: return coord_t'($urandom_range(0, 20)) - coord_t'(10);
            default: return coord_t'($urandom_range(0, 1 << 22)) - coord_t'(1 << 21);
        endcase
    endfunction

    // mostly boxes around points near the ray origin, so hits happen often
    function automatic ray_box_t rand_ray_box();
        ray_box_t rb;
        coord_t   c;
        coord_t   w;
        bit       aimed;
        aimed = $urandom_range(0, 3) != 0;
        for (int a = 0; a < 3; a++)
        begin
            rb.org[a] = rand_coord();
            rb.dir[a] = rand_coord();
            if (aimed)
            begin
                rb.org[a] = coord_t'($urandom_range(0, 1 << 22)) - coord_t'(1 << 21);
                rb.dir[a] = coord_t'($urandom_range(0, 1 << 18)) - coord_t'(1 << 17);
                c = rb.org[a] + coord_t'($urandom_range(0, 1 << 20)) - coord_t'(1 << 19);
                w = coord_t'($urandom_range(0, 1 << 20));
                rb.lo[a] = c - w;
                rb.hi[a] = c + w;
                if ($urandom_range(0, 9) == 0)
                    rb.dir[a] = coord_t'($urandom_range(0, 20)) - coord_t'(10);
            end
            else
            begin
                rb.lo[a] = rand_coord();
                rb.hi[a] = rand_coord();
            end
        end
        return rb;
    endfunction

    function automatic ray_box_t make_ray_box(coord_t o, coord_t dv, coord_t lo, coord_t hi);
        ray_box_t rb;
        for (int a = 0; a < 3; a++)
        begin
            rb.org[a] = o;
            rb.dir[a] = dv;
            rb.lo[a]  = lo;
            rb.hi[a]  = hi;
        end
        return rb;
    endfunction

    // result side: random stalls, checks against the oldest expectation
    initial
    begin
        hit_res_t exp_r;
        int       stall;
        stall = 0;
        hit_ch.ready <= 1'b0;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (hit_ch.valid && hit_ch.ready)
            begin
                results_seen++;
                if (expected_hits.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result transfer: hit=%0b dist=%0h",
                                 hit_ch.hit, hit_ch.hit_distance);
                end
                else
                begin
                    exp_r = expected_hits.pop_front();
                    if (exp_r.hit)
                        hits_seen++;
                    if (exp_r.hit !== hit_ch.hit || exp_r.distance !== hit_ch.hit_distance)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected hit=%0b dist=%0h, got hit=%0b dist=%0h",
                                     exp_r.hit, exp_r.distance, hit_ch.hit,
                                     hit_ch.hit_distance);
                    end
                end
                stall = sink_stall_enable ? $urandom_range(0, 5) : 0;
                if ($urandom_range(0, 3) == 0)
                    stall = 0;
                if (stall > 0)
                    hit_ch.ready <= 1'b0;
            end
            else if (!hit_ch.ready)
            begin
                if (stall > 0)
                    stall--;
                if (stall == 0)
                    hit_ch.ready <= 1'b1;
            end
        end
    end

    // watchdog on cycles with no transfer on any channel
    initial
    begin
        idle_cycles = 0;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if ((ray_ch.valid && ray_ch.ready) || (hit_ch.valid && hit_ch.ready)
                || (cfg_ch.valid && cfg_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog expired, %0d results outstanding", expected_hits.size());
                $display("[ray_aabb_slab_test] ERROR");
                $finish;
            end
        end
    end

    task automatic test_directed();
        coord_t one;
        ray_box_t rb;
        one = coord_t'(1) <<< FRAC_BITS;
        // straight hit along +x/+y/+z from outside
        send_ray(make_ray_box(0, one, 2 * one, 4 * one));
        // origin inside box, tmin stays 0
        send_ray(make_ray_box(one, one, 0, 2 * one));
        // negative direction
        send_ray(make_ray_box(5 * one, -one, one, 2 * one));
        // box behind the ray
        send_ray(make_ray_box(5 * one, one, one, 2 * one));
        // zero direction, inside then outside
        send_ray(make_ray_box(one, 0, 0, 2 * one));
        send_ray(make_ray_box(3 * one, 0, 0, 2 * one));
        // direction just below and at epsilon
        send_ray(make_ray_box(3 * one, coord_t'(6), 0, 2 * one));
        send_ray(make_ray_box(-one, coord_t'(7), 0, 2 * one));
        send_ray(make_ray_box(-one, coord_t'(-7), 0, 2 * one));
        // inverted box, parallel and non-parallel
        send_ray(make_ray_box(one, 0, 2 * one, 0));
        send_ray(make_ray_box(0, one, 2 * one, one));
        // saturating quotients: huge extent, tiny direction
        send_ray(make_ray_box(~COORD_MAX, coord_t'(8), 0, COORD_MAX));
        send_ray(make_ray_box(COORD_MAX, coord_t'(-8), ~COORD_MAX, 0));
        send_ray(make_ray_box(~COORD_MAX, ~COORD_MAX, ~COORD_MAX, COORD_MAX));
        send_ray(make_ray_box(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX));
        send_ray(make_ray_box(0, -1, -1, 0));
        // early miss on x, y and z wild
        rb = make_ray_box(0, one, one, 2 * one);
        rb.org[0] = 9 * one;
        rb.dir[0] = 0;
        rb.dir[1] = coord_t'(3);
        send_ray(rb);
        // miss only on z
        rb = make_ray_box(0, one, one, 2 * one);
        rb.lo[2] = 5 * one;
        rb.hi[2] = 6 * one;
        send_ray(rb);
    endtask

    task automatic test_random(int count);
        repeat (count) send_ray(rand_ray_box());
    endtask

    task automatic test_epsilon_settings();
        write_epsilon(16'hFFFF);
        test_random(250);
        write_epsilon(16'h0000);
        test_random(250);
        write_epsilon(16'h0100);
        test_random(250);
        write_epsilon(EPS_RESET);
    endtask

    initial
    begin
        rst_n = 1'b0;
        mismatches = 0;
        results_seen = 0;
        hits_seen = 0;
        items_sent = 0;
        eps_model = EPS_RESET;
        sink_stall_enable = 1'b1;
        ray_ch.valid <= 1'b0;
        ray_ch.origin_x <= '0;
        ray_ch.origin_y <= '0;
        ray_ch.origin_z <= '0;
        ray_ch.dir_x <= '0;
        ray_ch.dir_y <= '0;
        ray_ch.dir_z <= '0;
        ray_ch.min_x <= '0;
        ray_ch.min_y <= '0;
        ray_ch.min_z <= '0;
        ray_ch.max_x <= '0;
        ray_ch.max_y <= '0;
        ray_ch.max_z <= '0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.data <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random(350);
        test_epsilon_settings();
        // stretch with no stalls on the result side
        sink_stall_enable = 1'b0;
        test_random(200);
        ray_idle();
        sink_stall_enable = 1'b1;

        wait (expected_hits.size() == 0);
        repeat (PIPE_DEPTH + 10) @(posedge clk);
        $display("sent %0d ray-box pairs over four epsilon settings; %0d results, %0d hits",
                 items_sent, results_seen, hits_seen);
        if (mismatches == 0 && expected_hits.size() == 0)
            $display("[ray_aabb_slab_test] OK");
        else
        begin
            $display("%0d mismatches", mismatches);
            $display("[ray_aabb_slab_test] ERROR");
        end
        $finish;
    end
endmodule
